[sv/amx_pkg.sv]
package amx_pkg;

  localparam int unsigned MEM_WORDS = 128;
  localparam int unsigned MemAw     = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  localparam logic signed [32:0] FOLD_LIMIT = 33'sd999999;
  localparam logic        [31:0] FOLD_MOD   = 32'd1999999;

  localparam logic [6:0] OP_READ  = 7'd10;
  localparam logic [6:0] OP_WRITE = 7'd11;
  localparam logic [6:0] OP_LOAD  = 7'd20;
  localparam logic [6:0] OP_STORE = 7'd21;
  localparam logic [6:0] OP_ADD   = 7'd30;
  localparam logic [6:0] OP_SUB   = 7'd31;
  localparam logic [6:0] OP_DIV   = 7'd32;
  localparam logic [6:0] OP_MUL   = 7'd33;
  localparam logic [6:0] OP_BR    = 7'd40;
  localparam logic [6:0] OP_BRNEG = 7'd41;
  localparam logic [6:0] OP_BRZ   = 7'd42;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_ADDR = 2'd1;
  localparam logic [1:0] STATUS_DIVZ = 2'd2;

  typedef struct packed {
    logic signed [6:0]  command;
    logic        [9:0]  operand_address;
    logic signed [31:0] read_value;
  } in_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic               write_valid;
    logic signed [31:0] write_value;
    logic        [9:0]  next_pc;
    logic signed [31:0] accumulator_out;
  } out_t;

  typedef struct packed {
    logic accept;
    logic fetch;
    logic mul_load;
    logic iter_start;
    logic iter_fold;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic run_div;
    logic run_mul;
    logic iter_done;
  } dp_sts_t;

endpackage

[sv/amx_divider.sv]
module amx_divider import amx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quotient_o,
  output logic [31:0] remainder_o
);

  // radix-4 restoring: two quotient bits per cycle
  localparam int unsigned Steps = 32;
  localparam int unsigned CntW  = $clog2(Steps);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [63:0]     dd_q, dd_d;
  logic [31:0]     rem_q, rem_d, dv_q;
  logic [32:0]     r1, r2, dv_ext;
  logic            ge1, ge2;
  logic [31:0]     r1s;

  always_comb begin
    dv_ext = {1'b0, dv_q};
    r1     = {rem_q, dd_q[63]};
    ge1    = r1 >= dv_ext;
    r1s    = ge1 ? 32'(r1 - dv_ext) : r1[31:0];
    r2     = {r1s, dd_q[62]};
    ge2    = r2 >= dv_ext;
    rem_d  = ge2 ? 32'(r2 - dv_ext) : r2[31:0];
    dd_d   = {dd_q[61:0], ge1, ge2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntW'(Steps - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(Steps - 1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dd_q  <= dividend_i;
      dv_q  <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dd_q  <= dd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = dd_q;
  assign remainder_o = rem_q;

endmodule

[sv/amx_datapath.sv]
module amx_datapath import amx_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  in_t     in_data_i,
  input  dp_cmd_t cmd_i,
  output dp_sts_t sts_o,
  output out_t    out_data_o
);

  in_t                inst_q;
  logic        [31:0] m_q, acc_q, pc_unused;
  logic        [9:0]  pc_q;
  logic signed [63:0] prod_q;
  out_t               out_q, out_d;
  logic [31:0]        mem_q [MEM_WORDS];
  logic [MEM_WORDS-1:0] vld_q;

  logic [6:0]  op;
  logic        mem_op, addr_bad, divz, ok, branch;
  logic [MemAw-1:0] idx;
  logic [31:0] m_abs, acc_abs, quo32, acc_c;
  logic [63:0] prod_abs, iter_dd, quo;
  logic [31:0] iter_dv, rem;
  logic        big;
  logic signed [32:0] rs;
  logic        mem_we;
  logic [31:0] mem_wdata;

  assign pc_unused = '0;
  assign op  = inst_q.command[6] ? 7'(-inst_q.command) : inst_q.command;
  assign idx = inst_q.operand_address[MemAw-1:0];

  always_comb begin
    mem_op = (op == OP_READ) || (op == OP_WRITE) || (op == OP_LOAD) || (op == OP_STORE) ||
             (op == OP_ADD)  || (op == OP_SUB)   || (op == OP_DIV)  || (op == OP_MUL);
    addr_bad = mem_op && ({1'b0, inst_q.operand_address} >= 11'(MEM_WORDS));
    divz     = !addr_bad && (op == OP_DIV) && (m_q == '0);
    ok       = !addr_bad && !divz;
    m_abs    = m_q[31] ? 32'(-m_q) : m_q;
    acc_abs  = acc_q[31] ? 32'(-acc_q) : acc_q;
    prod_abs = prod_q[63] ? 64'(-prod_q) : 64'(prod_q);
    iter_dd  = cmd_i.iter_fold ? prod_abs : {32'd0, acc_abs};
    iter_dv  = cmd_i.iter_fold ? FOLD_MOD : m_abs;
  end

  amx_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.iter_start),
    .dividend_i  (iter_dd),
    .divisor_i   (iter_dv),
    .done_o      (sts_o.iter_done),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  assign sts_o.run_div = ok && (op == OP_DIV);
  assign sts_o.run_mul = ok && (op == OP_MUL);

  // result of the instruction, valid in the commit cycle
  always_comb begin
    quo32 = (acc_q[31] ^ m_q[31]) ? 32'(-quo[31:0]) : quo[31:0];
    big   = (prod_q > 64'(FOLD_LIMIT)) || (prod_q < -64'(FOLD_LIMIT));
    rs    = prod_q[63] ? -$signed({1'b0, rem}) : $signed({1'b0, rem});
    if (rs > FOLD_LIMIT)       rs = rs - $signed({1'b0, FOLD_MOD});
    else if (rs < -FOLD_LIMIT) rs = rs + $signed({1'b0, FOLD_MOD});
    acc_c  = acc_q;
    branch = 1'b0;
    unique case (op)
      OP_LOAD:  acc_c = m_q;
      OP_ADD:   acc_c = acc_q + m_q;
      OP_SUB:   acc_c = acc_q - m_q;
      OP_DIV:   if (ok) acc_c = quo32;
      OP_MUL:   acc_c = big ? rs[31:0] : prod_q[31:0];
      OP_BR:    branch = 1'b1;
      OP_BRNEG: branch = acc_q[31];
      OP_BRZ:   branch = (acc_q == '0);
      default:  acc_c = acc_q;
    endcase
    out_d.status          = addr_bad ? STATUS_ADDR : (divz ? STATUS_DIVZ : STATUS_OK);
    out_d.write_valid     = ok && (op == OP_WRITE);
    out_d.write_value     = out_d.write_valid ? m_q : '0;
    out_d.next_pc         = !ok ? pc_q : (branch ? inst_q.operand_address : pc_q + 10'd1);
    out_d.accumulator_out = ok ? acc_c : acc_q;
    mem_we    = cmd_i.commit && ok && ((op == OP_READ) || (op == OP_STORE));
    mem_wdata = (op == OP_READ) ? inst_q.read_value : acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      pc_q  <= '0;
      vld_q <= '0;
    end else if (cmd_i.commit) begin
      acc_q <= out_d.accumulator_out ^ pc_unused;
      pc_q  <= out_d.next_pc;
      if (mem_we) vld_q[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept)   inst_q <= in_data_i;
    if (cmd_i.fetch)    m_q    <= vld_q[idx] ? mem_q[idx] : '0;
    if (cmd_i.mul_load) prod_q <= $signed(m_q) * $signed(acc_q);
    if (mem_we)         mem_q[idx] <= mem_wdata;
    if (cmd_i.commit)   out_q  <= out_d;
  end

  assign out_data_o = out_q;

endmodule

[sv/amx_controller.sv]
module amx_controller import amx_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_EXEC, S_MSTART, S_ITER, S_COMMIT
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.accept     = (state_q == S_IDLE) && in_valid_i;
    cmd_o.fetch      = (state_q == S_FETCH);
    cmd_o.mul_load   = (state_q == S_EXEC) && sts_i.run_mul;
    cmd_o.iter_start = ((state_q == S_EXEC) && sts_i.run_div) || (state_q == S_MSTART);
    cmd_o.iter_fold  = (state_q == S_MSTART);
    cmd_o.commit     = (state_q == S_COMMIT) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.commit)     out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE:   if (in_valid_i) state_q <= S_FETCH;
        S_FETCH:  state_q <= S_EXEC;
        S_EXEC: begin
          if (sts_i.run_div)      state_q <= S_ITER;
          else if (sts_i.run_mul) state_q <= S_MSTART;
          else                    state_q <= S_COMMIT;
        end
        S_MSTART: state_q <= S_ITER;
        S_ITER:   if (sts_i.iter_done) state_q <= S_COMMIT;
        S_COMMIT: if (cmd_o.commit) state_q <= S_IDLE;
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[sv/accumulator_machine_execute_unit.sv]
// Executes one instruction of a decimal-opcode accumulator machine per
// transfer. Holds a 128-word memory, a 32-bit accumulator and a 10-bit
// program counter, all zero after reset. An instruction without an
// arithmetic loop passes through accept, memory read, execute and commit;
// divide and multiply also iterate in the shared radix-4 divider, which
// produces the quotient or the modulo-1999999 fold of the product.
// One instruction is in flight at a time; the finished result sits in an
// output register so the next instruction is taken while it waits.
module accumulator_machine_execute_unit import amx_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencing: fetch, execute, iterate, commit
  amx_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // architectural state, memory, multiplier and divider
  amx_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

  // only one instruction in flight
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transfer accepted while busy");

  // errors never emit a word
  a_err_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != STATUS_OK) |-> !out_data_o.write_valid)
    else $error("write emitted with error status");

  // unused write word is zero
  a_wval_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.write_valid |-> (out_data_o.write_value == '0))
    else $error("write_value nonzero without write_valid");

endmodule

[dv/amx_scoreboard.sv]
`timescale 1ns / 1ps
module amx_scoreboard import amx_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_data_i,
  output int   errors_o,
  output int   pending_o
);

  logic [31:0] mem_words [MEM_WORDS];
  logic [31:0] acc_q;
  logic [9:0]  pc_q;
  out_t        exp_results [$];

  function automatic logic [31:0] fold_mul(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    longint r;
    p = longint'(a) * longint'(b);
    r = p;
    if (r > 999999 || r < -999999) begin
      r = p % 1999999;
      if (r > 999999) r -= 1999999;
      if (r < -999999) r += 1999999;
    end
    return r[31:0];
  endfunction

  task automatic execute_instr(input in_t ins);
    out_t        res;
    int          op;
    logic [9:0]  a;
    logic [31:0] m;
    logic        mem_op;
    logic        taken;
    longint      q;
    op = (ins.command < 0) ? -int'(ins.command) : int'(ins.command);
    a = ins.operand_address;
    res = '0;
    taken = 1'b0;
    mem_op = (op == OP_READ || op == OP_WRITE || op == OP_LOAD || op == OP_STORE ||
              op == OP_ADD || op == OP_SUB || op == OP_DIV || op == OP_MUL);
    if (mem_op && a >= MEM_WORDS) begin
      res.status = STATUS_ADDR;
    end else begin
      m = mem_op ? mem_words[a] : '0;
      case (op)
        OP_READ:  mem_words[a] = ins.read_value;
        OP_WRITE: begin
          res.write_valid = 1'b1;
          res.write_value = m;
        end
        OP_LOAD:  acc_q = m;
        OP_STORE: mem_words[a] = acc_q;
        OP_ADD:   acc_q = acc_q + m;
        OP_SUB:   acc_q = acc_q - m;
        OP_DIV: begin
          if (m == 0) res.status = STATUS_DIVZ;
          else begin
            q = longint'($signed(acc_q)) / longint'($signed(m));
            acc_q = q[31:0];
          end
        end
        OP_MUL:   acc_q = fold_mul(acc_q, m);
        OP_BR:    taken = 1'b1;
        OP_BRNEG: taken = acc_q[31];
        OP_BRZ:   taken = (acc_q == 0);
        default: ;
      endcase
      if (res.status == STATUS_OK) pc_q = taken ? a : pc_q + 10'd1;
    end
    res.next_pc = pc_q;
    res.accumulator_out = acc_q;
    exp_results.push_back(res);
  endtask

  assign pending_o = exp_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_t e;
    if (!rst_ni) begin
      foreach (mem_words[i]) mem_words[i] = '0;
      acc_q = '0;
      pc_q = '0;
      errors_o <= 0;
      exp_results.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (exp_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data_i);
          errors_o <= errors_o + 1;
        end else begin
          e = exp_results.pop_front();
          if (e !== out_data_i) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, out_data_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) execute_instr(in_data_i);
    end
  end

endmodule

[dv/tb_accumulator_machine_execute_unit.sv]
`timescale 1ns / 1ps
module tb_accumulator_machine_execute_unit;
  import amx_pkg::*;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  in_t  in_data;
  out_t out_data;
  int   errors, pending;
  int   send_idle_pct, recv_idle_pct;
  logic recv_hold;

  accumulator_machine_execute_unit dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  amx_scoreboard u_scoreboard (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver stalls; a long hold-off lets the output register fill
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // one transfer; idle cycles before it per the current sender rate.
  // valid stays high after the transfer; the caller drops it when it stops sending
  task automatic send_instr(input logic signed [6:0] cmd, input logic [9:0] adr,
                            input logic [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{command: cmd, operand_address: adr, read_value: val};
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic signed [6:0] rand_cmd();
    logic [6:0] ops [11] = '{OP_READ, OP_WRITE, OP_LOAD, OP_STORE, OP_ADD, OP_SUB,
                             OP_DIV, OP_MUL, OP_BR, OP_BRNEG, OP_BRZ};
    logic signed [6:0] c;
    if ($urandom_range(9) == 0) c = 7'($urandom_range(127));  // any code, unknown mostly
    else c = ops[$urandom_range(10)];
    if ($urandom_range(1) && c != -64) c = -c;
    return c;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(4))
      0: return $urandom_range(3) - 1;
      1: return $urandom_range(2000);
      2: return -$urandom_range(2000);
      3: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    recv_hold = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every opcode, address limits, divide by zero and overflow
    send_instr(OP_WRITE, 10'd5, 32'd0);
    send_instr(OP_DIV, 10'd5, 32'd0);                 // divide by zero
    send_instr(OP_READ, 10'd127, 32'h8000_0000);
    send_instr(OP_READ, 10'd128, 32'd7);              // out of range
    send_instr(-OP_READ, 10'd1023, 32'hffff_ffff);    // out of range
    send_instr(OP_READ, 10'd0, 32'hffff_ffff);
    send_instr(OP_LOAD, 10'd127, 32'd0);
    send_instr(-OP_DIV, 10'd0, 32'd0);                // min / -1 wraps
    send_instr(OP_STORE, 10'd1, 32'd0);
    send_instr(OP_ADD, 10'd127, 32'd0);
    send_instr(-OP_SUB, 10'd0, 32'd0);
    send_instr(OP_READ, 10'd2, 32'h7fff_ffff);
    send_instr(OP_MUL, 10'd2, 32'd0);                 // fold of a large product
    send_instr(-OP_WRITE, 10'd2, 32'd0);
    send_instr(OP_BRNEG, 10'd1023, 32'd0);
    send_instr(-OP_BR, 10'd1022, 32'd0);
    send_instr(OP_BR, 10'd0, 32'd0);
    send_instr(OP_LOAD, 10'd3, 32'd0);
    send_instr(-OP_BRZ, 10'd700, 32'd0);
    send_instr(7'sd63, 10'd1023, 32'h5555_aaaa);      // unknown
    send_instr(-7'sd64, 10'd0, 32'haaaa_5555);        // unknown
    send_instr(7'sd0, 10'd512, 32'd0);
    send_instr(OP_DIV, 10'd600, 32'd0);

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? 73 : (ph == 2 ? 0 : 0);
      recv_idle_pct = (ph == 2 || ph == 3) ? 73 : 0;
      if (ph == 3) begin
        send_idle_pct = 8;
        recv_idle_pct = 8;
      end
      for (int n = 0; n < 370; n++) begin
        logic [9:0] adr;
        adr = ($urandom_range(19) == 0) ? 10'($urandom_range(1023)) :
              10'($urandom_range($urandom_range(1) ? 7 : 127));
        send_instr(rand_cmd(), adr, rand_word());
      end
      // pause until drained
      in_valid <= 1'b0;
      @(posedge clk);
      while (pending != 0) @(posedge clk);
    end

    // long receiver hold-off while the sender keeps offering
    send_idle_pct = 0;
    fork
      begin
        recv_hold = 1'b1;
        repeat (300) @(posedge clk);
        recv_hold = 1'b0;
      end
      for (int n = 0; n < 20; n++) send_instr(rand_cmd(), 10'($urandom_range(15)), rand_word());
    join
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
